[hw/rtl/pci_pkg.sv]
// Shared types, constants and helpers of the PVT cubic interpolator.
`default_nettype none

package pci_pkg;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 6;
  localparam int DATA_W   = 32;
  localparam int PERIOD_W = 20;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FAULT = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd10000;
  localparam logic [IDX_W-1:0]    START_RST  = 6'd0;
  localparam logic [IDX_W-1:0]    END_RST    = 6'd1;

  localparam int DIV_NUM_W = 84;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_QUO_W = 64;
  localparam int DIV_CNT_W = 7;

  // quotient widths of the divisions used
  localparam logic [DIV_CNT_W-1:0] N_U     = 7'd32;
  localparam logic [DIV_CNT_W-1:0] N_STEPS = 7'd32;
  localparam logic [DIV_CNT_W-1:0] N_SPEED = 7'd48;

  // 65536 / 1e6 = 1024 / 15625
  localparam logic [13:0]          VEL_DIV  = 14'd15625;
  // ceil(2^44 / 15625), exact quotient for dividends below 2^30
  localparam logic [31:0]          VEL_RCP  = 32'd1125899907;
  // 16-bit digits of the 80-bit dividend
  localparam logic [2:0]           ES_DIGITS = 3'd5;
  localparam logic [31:0]          US_PER_S = 32'd1000000;
  localparam logic [48:0]          SPEED_SAT = 49'h1_0000_0000_0000;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic [DATA_W-1:0]        tstamp;
  } tbl_entry_t;

  // Q16 to integer, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] q16_sat(input logic signed [63:0] q);
    logic [63:0] mag;
    logic [47:0] m;
    mag = q[63] ? (~q + 64'd1) : q;
    m   = mag[63:16];
    if (q[63]) begin
      if (m > 48'h0000_8000_0000) q16_sat = 32'h8000_0000;
      else q16_sat = ~m[31:0] + 32'd1;
    end else begin
      if (m > 48'h0000_7FFF_FFFF) q16_sat = 32'h7FFF_FFFF;
      else q16_sat = m[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pci_item_if.sv]
// Input item channel of the PVT cubic interpolator.
`default_nettype none

interface pci_item_if;
  logic                                valid;
  logic                                ready;
  logic [pci_pkg::MODE_W-1:0]          mode;
  logic [pci_pkg::IDX_W-1:0]           point_index;
  logic signed [pci_pkg::DATA_W-1:0]   point_position;
  logic signed [pci_pkg::DATA_W-1:0]   point_velocity;
  logic [pci_pkg::DATA_W-1:0]          point_time_us;

  modport source (output valid, mode, point_index, point_position, point_velocity,
                  point_time_us, input ready);
  modport sink (input valid, mode, point_index, point_position, point_velocity,
                point_time_us, output ready);
endinterface

`default_nettype wire

[hw/rtl/pci_result_if.sv]
// Result channel of the PVT cubic interpolator.
`default_nettype none

interface pci_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pci_pkg::DATA_W-1:0]   position_ref;
  logic signed [pci_pkg::DATA_W-1:0]   velocity_ref;
  logic [pci_pkg::STATUS_W-1:0]        status;
  logic                                running;

  modport source (output valid, position_ref, velocity_ref, status, running, input ready);
  modport sink (input valid, position_ref, velocity_ref, status, running, output ready);
endinterface

`default_nettype wire

[hw/rtl/pci_cfg_if.sv]
// Register write channel of the PVT cubic interpolator.
`default_nettype none

interface pci_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pci_pkg::CFG_IDX_W-1:0]     index;
  logic [pci_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pvt_cubic_interpolator.sv]
// PVT cubic Hermite trajectory interpolator with point table memory.
//
// Channels: item (sink) carries a write of a table point, a run start or a
// control tick; result (source) returns exactly one beat per item with the
// position and velocity references, a status code and the running flag.
// cfg (sink, always ready) writes period, start index, end index and pause.
// The point table is a synchronous memory with one registered read port.
// Writes, starts and idle ticks go from accept into the result registers and
// then the output register. A tick inside a segment (shorter when the slope
// saturates) is bounded by the shared radix-2 divider (position
// fraction, 32 steps; velocity scaling, 48 steps), by the velocity-distance
// scaling (5 reciprocal digit steps) and by the single 32x32 multiplier
// stepping through the Q31 products. The first tick of a segment also
// reads both points and builds the cubic coefficients and step count.
// One item is worked on at a time; the next one is taken as soon as its
// result sits in the output register.
// Reset stops any run and clears the control state; table contents are
// kept undefined until written. When the receiver stalls, the result beat
// holds; one more item may be taken and finished, then the input stalls.
`default_nettype none

module pvt_cubic_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  pci_item_if.sink            item,
  pci_result_if.source        result,
  pci_cfg_if.sink             cfg
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IDX_N = 2 ** pci_pkg::IDX_W;

  typedef enum logic [5:0] {
    ST_IDLE, ST_EMIT,
    SG_RD0, SG_RD1, SG_CHK, SG_E0, SG_E1, SG_CF, SG_CF3, SG_ST,
    TK_TAU, TK_CLIP, TK_UDIV, TK_U, TK_U2, TK_U3, TK_P0, TK_P1, TK_P2,
    TK_T0, TK_T1, TK_S0, TK_S1, TK_S2, TK_S3, TK_S4, TK_SQ, TK_V, TK_OUT,
    ES_MUL, ES_DS, ES_DG, ES_DR, ES_FIN, MQ_ABS, MQ_HI, MQ_LO, MQ_SUM, DV_GO, DV_WAIT
  } state_t;

  state_t state, ret, div_ret;

  // configuration
  logic [pci_pkg::PERIOD_W-1:0] period;
  logic [pci_pkg::IDX_W-1:0]    start_idx;
  logic [pci_pkg::IDX_W-1:0]    end_idx;
  logic                         pause;

  // run control
  logic          active;
  logic [AW-1:0] cur;
  logic [31:0]   step;
  logic [31:0]   steps;
  logic [15:0]   fault_count;

  // segment
  logic [31:0]        span;
  logic signed [31:0] org_p, org_v, p1, v1;
  logic signed [63:0] coef_a, coef_b, coef_a3, e0, ta;
  pci_pkg::tbl_entry_t ent0;

  // tick datapath
  logic [63:0]        tau_raw;
  logic [31:0]        tau, u, u2, u3;
  logic signed [63:0] accp, acct, accv;
  logic               tneg;
  logic [63:0]        tmag, sph, spl;
  logic [48:0]        sm;

  // velocity-distance helper
  logic signed [31:0] e_v;
  logic [31:0]        e_x;
  logic [63:0]        prod;
  logic signed [63:0] e_res;
  logic [79:0]        es_num;
  logic [13:0]        es_rem;
  logic [15:0]        es_qd;
  logic [63:0]        es_quo;
  logic [2:0]         es_cnt;
  logic [29:0]        es_x, es_back;

  // Q31 product helper
  logic signed [63:0] mq_c;
  logic [31:0]        mq_w;
  logic               mq_neg;
  logic [63:0]        mq_mag, mq_hi, mq_lo, mq_res;

  // results
  logic signed [31:0]           res_pos, res_vel;
  logic [pci_pkg::STATUS_W-1:0] res_status;
  logic                         out_valid, out_run;
  logic signed [31:0]           out_pos, out_vel;
  logic [pci_pkg::STATUS_W-1:0] out_status;

  // divider
  logic [pci_pkg::DIV_NUM_W-1:0] div_num;
  logic [pci_pkg::DIV_DEN_W-1:0] div_den;
  logic [pci_pkg::DIV_CNT_W-1:0] div_n;
  pci_pkg::div_req_t             div_req;
  pci_pkg::div_rsp_t             div_rsp;

  // table memory
  pci_pkg::tbl_entry_t mem [TABLE_DEPTH];
  pci_pkg::tbl_entry_t rd_data;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       nxt;
  logic                wr_en;

  logic [AW-1:0] mod_lut [IDX_N];

  genvar gi;
  for (gi = 0; gi < IDX_N; gi++) begin : g_mod
    assign mod_lut[gi] = AW'(gi % TABLE_DEPTH);
  end

  logic [pci_pkg::PERIOD_W-1:0] per_eff;
  logic [31:0]                  seg_d;
  logic [31:0]                  ev_mag;
  logic [31:0]                  mul_x, mul_y;
  logic [63:0]                  mul_p;
  logic signed [63:0]           mq_sv, sm_sv, dp64, org_p64, org_v64;
  logic signed [32:0]           dp;
  logic [31:0]                  step_next;

  always_comb begin
    per_eff   = (period == '0) ? pci_pkg::PERIOD_W'(1) : period;
    seg_d     = (span == 32'd0) ? 32'd1 : span;
    ev_mag    = e_v[31] ? (~e_v + 32'd1) : e_v;
    nxt       = (cur == AW'(TABLE_DEPTH - 1)) ? '0 : cur + AW'(1);
    rd_addr   = (state == SG_RD1) ? nxt : cur;
    mq_sv     = mq_neg ? -$signed(mq_res) : $signed(mq_res);
    sm_sv     = tneg ? -$signed({15'b0, sm}) : $signed({15'b0, sm});
    dp        = $signed({p1[31], p1}) - $signed({org_p[31], org_p});
    dp64      = 64'(dp);
    org_p64   = 64'(org_p);
    org_v64   = 64'(org_v);
    step_next = step + 32'd1;
    es_x      = {es_rem, es_num[79:64]};
    es_back   = 30'(es_qd) * 30'(pci_pkg::VEL_DIV);
    wr_en     = (state == ST_IDLE) && item.valid && (item.mode == pci_pkg::MODE_WRITE) &&
                (32'(item.point_index) < 32'(TABLE_DEPTH));
  end

  // shared 32x32 multiplier
  always_comb begin
    unique case (state)
      ES_MUL:  begin mul_x = ev_mag;        mul_y = e_x;               end
      ES_DG:   begin mul_x = {2'b0, es_x};  mul_y = pci_pkg::VEL_RCP;  end
      MQ_HI:   begin mul_x = mq_mag[63:32]; mul_y = mq_w;              end
      MQ_LO:   begin mul_x = mq_mag[31:0];  mul_y = mq_w;              end
      TK_TAU:  begin mul_x = step;          mul_y = 32'(per_eff);      end
      TK_U2:   begin mul_x = u;             mul_y = u;                 end
      TK_U3:   begin mul_x = u2;            mul_y = u;                 end
      TK_S2:   begin mul_x = tmag[63:32];   mul_y = pci_pkg::US_PER_S; end
      TK_S3:   begin mul_x = tmag[31:0];    mul_y = pci_pkg::US_PER_S; end
      default: begin mul_x = '0;            mul_y = '0;                end
    endcase
    mul_p = {32'b0, mul_x} * {32'b0, mul_y};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(item.point_index)] <= '{pos: item.point_position, vel: item.point_velocity,
                                       tstamp: item.point_time_us};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= pci_pkg::PERIOD_RST;
      start_idx <= pci_pkg::START_RST;
      end_idx   <= pci_pkg::END_RST;
      pause     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pci_pkg::CFG_PERIOD: period    <= cfg.data;
        pci_pkg::CFG_START:  start_idx <= cfg.data[pci_pkg::IDX_W-1:0];
        pci_pkg::CFG_END:    end_idx   <= cfg.data[pci_pkg::IDX_W-1:0];
        pci_pkg::CFG_PAUSE:  pause     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  assign div_req.start = (state == DV_GO);
  assign div_req.nbits = div_n;
  assign div_req.num   = div_num;
  assign div_req.den   = div_den;

  pci_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 1'b0;
      cur         <= '0;
      step        <= '0;
      steps       <= '0;
      fault_count <= '0;
      out_valid   <= 1'b0;
      span        <= '0;
    end else begin
      if (result.ready && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            res_pos    <= '0;
            res_vel    <= '0;
            res_status <= pci_pkg::STAT_NONE;
            state      <= ST_EMIT;
            unique case (item.mode)
              pci_pkg::MODE_START: begin
                active <= 1'b1;
                cur    <= mod_lut[start_idx];
                step   <= '0;
              end
              pci_pkg::MODE_TICK: begin
                if (active) state <= (step == 32'd0) ? SG_RD0 : TK_TAU;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_pos    <= res_pos;
            out_vel    <= res_vel;
            out_status <= res_status;
            out_run    <= active;
            state      <= ST_IDLE;
          end
        end
        SG_RD0: state <= SG_RD1;
        SG_RD1: begin
          ent0  <= rd_data;
          state <= SG_CHK;
        end
        SG_CHK: begin
          if (cur == mod_lut[end_idx]) begin
            active     <= 1'b0;
            res_status <= pci_pkg::STAT_DONE;
            step       <= '0;
            state      <= ST_EMIT;
          end else if (rd_data.tstamp <= ent0.tstamp) begin
            active      <= 1'b0;
            res_status  <= pci_pkg::STAT_FAULT;
            steps       <= '0;
            step        <= '0;
            fault_count <= fault_count + 16'd1;
            state       <= ST_EMIT;
          end else begin
            span  <= rd_data.tstamp - ent0.tstamp;
            org_p <= ent0.pos;
            org_v <= ent0.vel;
            p1    <= rd_data.pos;
            v1    <= rd_data.vel;
            e_v   <= ent0.vel;
            e_x   <= rd_data.tstamp - ent0.tstamp;
            ret   <= SG_E0;
            state <= ES_MUL;
          end
        end
        SG_E0: begin
          e0    <= e_res;
          e_v   <= v1;
          e_x   <= span;
          ret   <= SG_E1;
          state <= ES_MUL;
        end
        SG_E1: begin
          ta    <= e0 + e_res;
          state <= SG_CF;
        end
        SG_CF: begin
          // A = -2*dp*2^16 + e0 + e1, B = 3*dp*2^16 - 2*e0 - e1
          coef_a <= ta - (dp64 <<< 17);
          coef_b <= (dp64 <<< 17) + (dp64 <<< 16) - e0 - ta;
          state  <= SG_CF3;
        end
        SG_CF3: begin
          coef_a3 <= coef_a + (coef_a <<< 1);
          div_num <= pci_pkg::DIV_NUM_W'(span);
          div_den <= 32'(per_eff);
          div_n   <= pci_pkg::N_STEPS;
          div_ret <= SG_ST;
          state   <= DV_GO;
        end
        SG_ST: begin
          steps <= (div_rsp.quo == '0) ? 32'd1 : div_rsp.quo[31:0];
          state <= TK_TAU;
        end
        TK_TAU: begin
          tau_raw <= mul_p;
          state   <= TK_CLIP;
        end
        TK_CLIP: begin
          tau   <= (tau_raw > {32'b0, seg_d}) ? seg_d : tau_raw[31:0];
          state <= TK_UDIV;
        end
        TK_UDIV: begin
          div_num <= {21'b0, tau, 31'b0};
          div_den <= seg_d;
          div_n   <= pci_pkg::N_U;
          div_ret <= TK_U;
          state   <= DV_GO;
        end
        TK_U: begin
          u     <= div_rsp.quo[31:0];
          state <= TK_U2;
        end
        TK_U2: begin
          u2    <= 32'(mul_p >> 31);
          state <= TK_U3;
        end
        TK_U3: begin
          u3    <= 32'(mul_p >> 31);
          e_v   <= org_v;
          e_x   <= tau;
          ret   <= TK_P0;
          state <= ES_MUL;
        end
        TK_P0: begin
          accp  <= (org_p64 <<< 16) + e_res;
          mq_c  <= coef_b;
          mq_w  <= u2;
          ret   <= TK_P1;
          state <= MQ_ABS;
        end
        TK_P1: begin
          accp  <= accp + mq_sv;
          mq_c  <= coef_a;
          mq_w  <= u3;
          ret   <= TK_P2;
          state <= MQ_ABS;
        end
        TK_P2: begin
          accp  <= accp + mq_sv;
          mq_c  <= coef_b <<< 1;
          mq_w  <= u;
          ret   <= TK_T0;
          state <= MQ_ABS;
        end
        TK_T0: begin
          acct  <= mq_sv;
          mq_c  <= coef_a3;
          mq_w  <= u2;
          ret   <= TK_T1;
          state <= MQ_ABS;
        end
        TK_T1: begin
          acct  <= acct + mq_sv;
          state <= TK_S0;
        end
        TK_S0: begin
          tneg  <= acct[63];
          tmag  <= acct[63] ? (~acct + 64'd1) : acct;
          state <= TK_S1;
        end
        TK_S1: begin
          // quotient |t|/d of 2^28 or more saturates the scaled slope
          if (tmag >= {4'b0, seg_d, 28'b0}) begin
            sm    <= pci_pkg::SPEED_SAT;
            state <= TK_V;
          end else begin
            state <= TK_S2;
          end
        end
        TK_S2: begin
          sph   <= mul_p;
          state <= TK_S3;
        end
        TK_S3: begin
          spl   <= mul_p;
          state <= TK_S4;
        end
        TK_S4: begin
          div_num <= ({20'b0, sph} << 32) + {20'b0, spl};
          div_den <= seg_d;
          div_n   <= pci_pkg::N_SPEED;
          div_ret <= TK_SQ;
          state   <= DV_GO;
        end
        TK_SQ: begin
          sm    <= div_rsp.quo[48:0];
          state <= TK_V;
        end
        TK_V: begin
          accv  <= (org_v64 <<< 16) + sm_sv;
          state <= TK_OUT;
        end
        TK_OUT: begin
          res_pos <= pci_pkg::q16_sat(accp);
          res_vel <= pci_pkg::q16_sat(accv);
          if (step_next == steps) begin
            step <= '0;
            if (pause) begin
              active     <= 1'b0;
              res_status <= pci_pkg::STAT_DONE;
            end else begin
              cur <= nxt;
            end
          end else begin
            step <= step_next;
          end
          state <= ST_EMIT;
        end
        // v * x * 1024 / 15625, truncated toward zero
        ES_MUL: begin
          prod  <= mul_p;
          state <= ES_DS;
        end
        ES_DS: begin
          es_num <= {6'b0, prod, 10'b0};
          es_rem <= '0;
          es_quo <= '0;
          es_cnt <= pci_pkg::ES_DIGITS;
          state  <= ES_DG;
        end
        // one 16-bit quotient digit per pass, remainder stays below 15625
        ES_DG: begin
          es_qd <= mul_p[59:44];
          state <= ES_DR;
        end
        ES_DR: begin
          es_rem <= 14'(es_x - es_back);
          es_quo <= {es_quo[47:0], es_qd};
          es_num <= es_num << 16;
          es_cnt <= es_cnt - 3'd1;
          state  <= (es_cnt == 3'd1) ? ES_FIN : ES_DG;
        end
        ES_FIN: begin
          e_res <= e_v[31] ? -$signed(es_quo) : $signed(es_quo);
          state <= ret;
        end
        // |c| * w / 2^31 from two 32-bit partial products
        MQ_ABS: begin
          mq_neg <= mq_c[63];
          mq_mag <= mq_c[63] ? (~mq_c + 64'd1) : mq_c;
          state  <= MQ_HI;
        end
        MQ_HI: begin
          mq_hi <= mul_p;
          state <= MQ_LO;
        end
        MQ_LO: begin
          mq_lo <= mul_p;
          state <= MQ_SUM;
        end
        MQ_SUM: begin
          mq_res <= (mq_hi << 1) + (mq_lo >> 31);
          state  <= ret;
        end
        DV_GO: state <= DV_WAIT;
        DV_WAIT: begin
          if (div_rsp.done) state <= div_ret;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign item.ready          = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.position_ref = out_pos;
  assign result.velocity_ref = out_vel;
  assign result.status       = out_status;
  assign result.running      = out_run;

endmodule

`default_nettype wire

[hw/rtl/pci_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, quotient width per request.
`default_nettype none

module pci_div (
  input  logic              clk,
  input  logic              rst,
  input  pci_pkg::div_req_t req,
  output pci_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic [pci_pkg::DIV_CNT_W-1:0]       cnt;
  logic [pci_pkg::DIV_DEN_W-1:0]       rem;
  logic [pci_pkg::DIV_DEN_W-1:0]       den;
  logic [pci_pkg::DIV_NUM_W-1:0]       sh;
  logic [pci_pkg::DIV_QUO_W-1:0]       quo;
  logic [pci_pkg::DIV_DEN_W:0]         trial;
  logic                                ge;

  always_comb begin
    trial = {rem, sh[pci_pkg::DIV_NUM_W-1]};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // high part of the dividend is below the divisor by construction
        busy <= 1'b1;
        cnt  <= req.nbits;
        rem  <= pci_pkg::DIV_DEN_W'(req.num >> req.nbits);
        sh   <= req.num << (pci_pkg::DIV_NUM_W - int'(req.nbits));
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        sh  <= sh << 1;
        rem <= ge ? pci_pkg::DIV_DEN_W'(trial - {1'b0, den}) : trial[pci_pkg::DIV_DEN_W-1:0];
        quo <= {quo[pci_pkg::DIV_QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == pci_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire
